@@ hw/rtl/ddpd_pkg.sv @@
// shared types and constants for the differential drive controller
package ddpd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int DUTY_W   = 7;
  localparam int ERR_W    = 15;
  localparam int CTRL_W   = 24;
  localparam int PROD_W   = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_OPEN = 2'd1;
  localparam logic [1:0] MODE_POS  = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OPEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_OPEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_NOM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_NOM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd7;

  localparam logic [DUTY_W-1:0] NOMINAL_RESET    = 7'd100;
  localparam logic [15:0]       PROP_GAIN_RESET  = 16'd3277;
  localparam logic [15:0]       DERIV_GAIN_RESET = 16'd328;

  typedef struct packed {
    logic                fill;
    logic                shift;
    logic                div_start;
    logic [SAMPLE_W-1:0] sample;
  } lane_ctl_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] newer;
    logic [SAMPLE_W-1:0] older;
  } lane_sts_t;

endpackage

@@ hw/rtl/ddpd_if.sv @@
// valid/ready channel interfaces for sensor items and duty results
interface ddpd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  mode;
  logic [11:0] right_sample;
  logic [11:0] left_sample;
  modport source (output valid, operation, mode, right_sample, left_sample, input ready);
  modport sink (input valid, operation, mode, right_sample, left_sample, output ready);
endinterface

interface ddpd_out_if;
  logic       valid;
  logic       ready;
  logic       duty_write;
  logic [6:0] right_duty;
  logic [6:0] left_duty;
  logic       tape_detected;
  logic       watch_armed;
  modport source (output valid, duty_write, right_duty, left_duty, tape_detected,
                  watch_armed, input ready);
  modport sink (input valid, duty_write, right_duty, left_duty, tape_detected,
                watch_armed, output ready);
endinterface

@@ hw/rtl/ddpd_lane.sv @@
// one sensor side: sample window, running half sums and reciprocal mean multipliers
module ddpd_lane import ddpd_pkg::*; #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_ctl_t ctl,
  output lane_sts_t sts
);

  localparam int H     = WINDOW_DEPTH / 2;
  localparam int TAPS  = 2 * H;
  localparam int SUM_W = SAMPLE_W + $clog2(H);
  localparam int RK    = SUM_W + $clog2(H);
  localparam int RM_W  = SUM_W + 2;
  localparam int PR_W  = SUM_W + RM_W;
  localparam longint RECIP_L = ((longint'(1) << RK) + longint'(H - 1)) / longint'(H);
  localparam logic [RM_W-1:0] RECIP = RM_W'(RECIP_L);

  logic [SAMPLE_W-1:0] win_r [TAPS];
  logic [SUM_W-1:0]    newer_sum_r, older_sum_r;
  logic [SAMPLE_W-1:0] newer_r, older_r;
  logic                done_r;

  logic [PR_W-1:0]  prod_n, prod_o;
  logic [SUM_W-1:0] seed_sum;

  assign seed_sum = SUM_W'(ctl.sample) * SUM_W'(H);

  // floor mean by the half length as a multiply by its rounded-up reciprocal
  assign prod_n = PR_W'(newer_sum_r) * PR_W'(RECIP);
  assign prod_o = PR_W'(older_sum_r) * PR_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) win_r[i] <= '0;
      newer_sum_r <= '0;
      older_sum_r <= '0;
      newer_r     <= '0;
      older_r     <= '0;
      done_r      <= 1'b0;
    end else begin
      done_r <= ctl.div_start;
      if (ctl.fill) begin
        for (int i = 0; i < TAPS; i++) win_r[i] <= ctl.sample;
        newer_sum_r <= seed_sum;
        older_sum_r <= seed_sum;
      end else if (ctl.shift) begin
        win_r[0] <= ctl.sample;
        for (int i = 1; i < TAPS; i++) win_r[i] <= win_r[i-1];
        // entries leaving each half move the sums along
        newer_sum_r <= newer_sum_r + SUM_W'(ctl.sample) - SUM_W'(win_r[H-1]);
        older_sum_r <= older_sum_r + SUM_W'(win_r[H-1]) - SUM_W'(win_r[TAPS-1]);
      end
      if (ctl.div_start) begin
        newer_r <= prod_n[RK +: SAMPLE_W];
        older_r <= prod_o[RK +: SAMPLE_W];
      end
    end
  end

  assign sts.done  = done_r;
  assign sts.newer = newer_r;
  assign sts.older = older_r;

endmodule

@@ hw/rtl/differential_drive_pd_with_tape_watch_unit.sv @@
// top level: mode control, PD law, tape watch merge and result register
// Takes one item at a time. An arm request, an off tick, an unused mode or an open-loop
// tick that is still filling the window goes from S_IDLE through S_FIN to a result; an
// open-loop tick with a full window also passes S_WSTART and S_WAIT, for the reciprocal multiplies that form
// the two half means in each of the sensor lanes, which run side by side; a position
// tick passes S_POS1 to S_POS4 through the two gain multipliers, the
// control sum and the saturation step. The input is free again as soon as the result is
// in the output register, and that register holds it until it is taken.
module differential_drive_pd_with_tape_watch_unit import ddpd_pkg::*; #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ddpd_in_if.sink               in_ch,
  ddpd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FC_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WSTART, S_WAIT, S_POS1, S_POS2, S_POS3, S_POS4, S_FIN
  } state_t;

  state_t state_r;

  logic [DUTY_W-1:0]     right_open_r, left_open_r, left_nom_r, right_nom_r;
  logic signed [12:0]    target_r;
  logic [SAMPLE_W-1:0]   thr_r;
  logic [15:0]           prop_r, deriv_r;

  logic [1:0]            prev_mode_r;
  logic                  watch_r;
  logic [FC_W-1:0]       fill_r;
  logic signed [ERR_W-1:0]  pe_r, e_r;
  logic signed [CTRL_W-1:0] pc_r;
  logic signed [PROD_W-1:0] m1_r, m2_r, c_r;

  logic              res_wr_r, res_tape_r, res_armed_r;
  logic [DUTY_W-1:0] res_rd_r, res_ld_r;

  logic              out_valid_r, out_wr_r, out_tape_r, out_armed_r;
  logic [DUTY_W-1:0] out_rd_r, out_ld_r;

  lane_ctl_t ctl_r_side, ctl_l_side;
  lane_sts_t sts_r_side, sts_l_side;

  logic accept;
  logic [FC_W-1:0] fc_eff;
  logic signed [ERR_W-1:0] e_new;
  logic signed [18:0] gain_sum;
  logic signed [17:0] gain_dif;
  logic signed [PROD_W-1:0] lnom_q, rnom_q, ql, qr;
  logic c_pos, c_neg, tape_r_side, tape_l_side;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign fc_eff = (prev_mode_r != MODE_OPEN) ? '0 : fill_r;
  assign e_new  = ERR_W'(target_r)
                - ($signed({3'b0, in_ch.left_sample}) - $signed({3'b0, in_ch.right_sample}));

  assign gain_sum = $signed({3'b0, prop_r}) + $signed({3'b0, deriv_r});
  assign gain_dif = $signed({2'b0, prop_r}) - $signed({2'b0, deriv_r});

  assign lnom_q = $signed({11'b0, left_nom_r, 16'b0});
  assign rnom_q = $signed({11'b0, right_nom_r, 16'b0});
  assign ql     = lnom_q - c_r;
  assign qr     = rnom_q + c_r;
  assign c_pos  = !c_r[PROD_W-1] && (c_r != '0);
  assign c_neg  = c_r[PROD_W-1];

  // merge: tape on either side when newer mean plus threshold falls below older mean
  assign tape_r_side = ({1'b0, sts_r_side.newer} + {1'b0, thr_r}) < {1'b0, sts_r_side.older};
  assign tape_l_side = ({1'b0, sts_l_side.newer} + {1'b0, thr_r}) < {1'b0, sts_l_side.older};

  always_comb begin
    ctl_r_side.fill      = accept && (in_ch.operation == OP_ARM);
    ctl_r_side.shift     = accept && (in_ch.operation == OP_TICK)
                         && (in_ch.mode == MODE_OPEN) && watch_r;
    ctl_r_side.div_start = (state_r == S_WSTART);
    ctl_r_side.sample    = in_ch.right_sample;
    ctl_l_side           = ctl_r_side;
    ctl_l_side.sample    = in_ch.left_sample;
  end

  ddpd_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_right (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_r_side), .sts(sts_r_side)
  );

  ddpd_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_left (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_l_side), .sts(sts_l_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_open_r <= '0;
      left_open_r  <= '0;
      target_r     <= '0;
      left_nom_r   <= NOMINAL_RESET;
      right_nom_r  <= NOMINAL_RESET;
      thr_r        <= '0;
      prop_r       <= PROP_GAIN_RESET;
      deriv_r      <= DERIV_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RIGHT_OPEN: right_open_r <= cfg_data[DUTY_W-1:0];
        REG_LEFT_OPEN:  left_open_r  <= cfg_data[DUTY_W-1:0];
        REG_TARGET:     target_r     <= $signed(cfg_data[12:0]);
        REG_LEFT_NOM:   left_nom_r   <= cfg_data[DUTY_W-1:0];
        REG_RIGHT_NOM:  right_nom_r  <= cfg_data[DUTY_W-1:0];
        REG_THRESHOLD:  thr_r        <= cfg_data[SAMPLE_W-1:0];
        REG_PROP_GAIN:  prop_r       <= cfg_data;
        REG_DERIV_GAIN: deriv_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_mode_r <= MODE_OFF;
      watch_r     <= 1'b0;
      fill_r      <= '0;
      pe_r        <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_wr_r    <= 1'b0;
            res_rd_r    <= '0;
            res_ld_r    <= '0;
            res_tape_r  <= 1'b0;
            res_armed_r <= watch_r;
            state_r     <= S_FIN;
            if (in_ch.operation == OP_ARM) begin
              watch_r     <= 1'b1;
              res_armed_r <= 1'b1;
            end else begin
              prev_mode_r <= in_ch.mode;
              unique case (in_ch.mode)
                MODE_OFF: res_wr_r <= (prev_mode_r != MODE_OFF);
                MODE_OPEN: begin
                  res_wr_r <= 1'b1;
                  res_rd_r <= right_open_r;
                  res_ld_r <= left_open_r;
                  fill_r   <= fc_eff;
                  if (watch_r) begin
                    if (fc_eff < FC_W'(WINDOW_DEPTH)) begin
                      fill_r <= fc_eff + 1'b1;
                    end else begin
                      state_r <= S_WSTART;
                    end
                  end
                end
                MODE_POS: begin
                  e_r     <= e_new;
                  state_r <= S_POS1;
                  if (prev_mode_r != MODE_POS) begin
                    pe_r <= '0;
                    pc_r <= '0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_WSTART: state_r <= S_WAIT;
        S_WAIT: begin
          if (sts_r_side.done) begin
            if (tape_r_side || tape_l_side) begin
              res_tape_r  <= 1'b1;
              res_armed_r <= 1'b0;
              watch_r     <= 1'b0;
              fill_r      <= '0;
            end
            state_r <= S_FIN;
          end
        end
        S_POS1: begin
          m1_r    <= PROD_W'(gain_sum * e_r);
          state_r <= S_POS2;
        end
        S_POS2: begin
          m2_r    <= PROD_W'(gain_dif * pe_r);
          state_r <= S_POS3;
        end
        S_POS3: begin
          c_r     <= m1_r + m2_r - PROD_W'(pc_r);
          state_r <= S_POS4;
        end
        S_POS4: begin
          res_wr_r <= 1'b1;
          pe_r     <= e_r;
          pc_r     <= c_r[CTRL_W-1:0];
          res_rd_r <= right_nom_r;
          res_ld_r <= left_nom_r;
          if (c_pos) begin
            // left slows; at or below minus one duty step it pins at zero
            if (ql <= -PROD_W'(65536)) begin
              res_ld_r <= '0;
              pc_r     <= lnom_q[CTRL_W-1:0];
            end else begin
              res_ld_r <= ql[PROD_W-1] ? '0 : ql[22:16];
            end
          end else if (c_neg) begin
            if (qr <= -PROD_W'(65536)) begin
              res_rd_r <= '0;
              pc_r     <= CTRL_W'(-rnom_q);
            end else begin
              res_rd_r <= qr[PROD_W-1] ? '0 : qr[22:16];
            end
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_wr_r    <= res_wr_r;
            out_rd_r    <= res_rd_r;
            out_ld_r    <= res_ld_r;
            out_tape_r  <= res_tape_r;
            out_armed_r <= res_armed_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty_write    = out_wr_r;
  assign out_ch.right_duty    = out_rd_r;
  assign out_ch.left_duty     = out_ld_r;
  assign out_ch.tape_detected = out_tape_r;
  assign out_ch.watch_armed   = out_armed_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FC_W'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_tape_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tape_r) |-> !out_armed_r && out_wr_r)
    else $error("tape result left the watch armed");

  a_arm_sets_watch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.operation == OP_ARM) |=> watch_r)
    else $error("arm request did not arm the watch");

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    sts_r_side.done == sts_l_side.done)
    else $error("lane mean stages out of step");

endmodule

@@ sim/tb.sv @@
// testbench for the differential drive controller: random and directed ticks, checked by a predictor
`timescale 1ns / 100ps

module tb;
  import ddpd_pkg::*;

  localparam int DEPTH = 8;

  typedef struct packed {
    logic                operation;
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] right_sample;
    logic [SAMPLE_W-1:0] left_sample;
  } tick_t;

  typedef struct packed {
    logic              duty_write;
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;
    logic              tape_detected;
    logic              watch_armed;
  } duty_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ddpd_in_if in_ch ();
  ddpd_out_if out_ch ();

  differential_drive_pd_with_tape_watch_unit #(.WINDOW_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [6:0]  p_right_open, p_left_open, p_left_nom, p_right_nom;
  logic signed [12:0] p_target;
  logic [11:0] p_threshold;
  logic [15:0] p_prop, p_deriv;
  logic [1:0]  p_prev_mode;
  logic        p_watch;
  int          p_fill;
  logic [11:0] p_rwin [DEPTH];
  logic [11:0] p_lwin [DEPTH];
  longint      p_prev_err, p_prev_ctrl;

  tick_t  tick_q [$];
  duty_t  duty_q [$];
  int     mismatches = 0;
  int     sent = 0;
  bit     stim_done = 0;

  function automatic longint half_avg(logic [11:0] w [DEPTH], int start);
    longint s;
    s = 0;
    for (int i = 0; i < DEPTH / 2; i++) s += w[start + i];
    return s / (DEPTH / 2);
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [15:0] v);
    case (idx)
      REG_RIGHT_OPEN: p_right_open = v[6:0];
      REG_LEFT_OPEN:  p_left_open = v[6:0];
      REG_TARGET:     p_target = v[12:0];
      REG_LEFT_NOM:   p_left_nom = v[6:0];
      REG_RIGHT_NOM:  p_right_nom = v[6:0];
      REG_THRESHOLD:  p_threshold = v[11:0];
      REG_PROP_GAIN:  p_prop = v;
      default:        p_deriv = v;
    endcase
  endfunction

  function automatic duty_t predict_duty(tick_t t);
    duty_t r;
    longint e, c, q, lnom, rnom, nr, orr, nl, ol;
    r = '0;
    if (t.operation == OP_ARM) begin
      p_watch = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
        p_rwin[i] = t.right_sample;
        p_lwin[i] = t.left_sample;
      end
    end else begin
      if (t.mode == MODE_OFF) begin
        r.duty_write = (p_prev_mode != MODE_OFF);
      end else if (t.mode == MODE_OPEN) begin
        if (p_prev_mode != MODE_OPEN) p_fill = 0;
        r.duty_write = 1'b1;
        r.right_duty = p_right_open;
        r.left_duty = p_left_open;
        if (p_watch) begin
          for (int i = DEPTH - 1; i > 0; i--) begin
            p_rwin[i] = p_rwin[i-1];
            p_lwin[i] = p_lwin[i-1];
          end
          p_rwin[0] = t.right_sample;
          p_lwin[0] = t.left_sample;
          if (p_fill < DEPTH) begin
            p_fill++;
          end else begin
            nr = half_avg(p_rwin, 0);
            orr = half_avg(p_rwin, DEPTH / 2);
            nl = half_avg(p_lwin, 0);
            ol = half_avg(p_lwin, DEPTH / 2);
            if (nr + p_threshold < orr || nl + p_threshold < ol) begin
              r.tape_detected = 1'b1;
              p_watch = 1'b0;
              p_fill = 0;
            end
          end
        end
      end else if (t.mode == MODE_POS) begin
        e = longint'(p_target) - (longint'(t.left_sample) - longint'(t.right_sample));
        lnom = longint'(p_left_nom) * 65536;
        rnom = longint'(p_right_nom) * 65536;
        if (p_prev_mode != MODE_POS) begin
          p_prev_err = 0;
          p_prev_ctrl = 0;
        end
        c = (longint'(p_prop) + longint'(p_deriv)) * e
          + (longint'(p_prop) - longint'(p_deriv)) * p_prev_err - p_prev_ctrl;
        r.duty_write = 1'b1;
        if (c > 0) begin
          r.right_duty = p_right_nom;
          q = lnom - c;
          if (q <= -65536) begin
            r.left_duty = 0;
            c = lnom;
          end else begin
            r.left_duty = (q < 0) ? 7'd0 : 7'(q >>> 16);
          end
        end else if (c < 0) begin
          r.left_duty = p_left_nom;
          q = rnom + c;
          if (q <= -65536) begin
            r.right_duty = 0;
            c = -rnom;
          end else begin
            r.right_duty = (q < 0) ? 7'd0 : 7'(q >>> 16);
          end
        end else begin
          r.right_duty = p_right_nom;
          r.left_duty = p_left_nom;
        end
        p_prev_ctrl = c;
        p_prev_err = e;
      end
      p_prev_mode = t.mode;
    end
    r.watch_armed = p_watch;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // driver
  int in_gap = 0;
  logic in_acc = 1'b0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.mode = MODE_OFF;
    in_ch.right_sample = '0;
    in_ch.left_sample = '0;
  end

  // transfer seen at the rising edge, used by the driver at the next falling edge
  always @(posedge clk) in_acc <= rst_n && in_ch.valid && in_ch.ready;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) in_gap = gap_len();
      if (!in_ch.valid || in_acc) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tick_t t;
          t = tick_q.pop_front();
          duty_q.push_back(predict_duty(t));
          in_ch.valid <= 1'b1;
          in_ch.operation <= t.operation;
          in_ch.mode <= t.mode;
          in_ch.right_sample <= t.right_sample;
          in_ch.left_sample <= t.left_sample;
          sent++;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor, with random stalls on the result side
  int out_gap = 0;
  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      duty_t got, want;
      got = '{out_ch.duty_write, out_ch.right_duty, out_ch.left_duty,
              out_ch.tape_detected, out_ch.watch_armed};
      if (duty_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = duty_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic set_reg(logic [2:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (tick_q.size() == 0 && duty_q.size() == 0 && !in_ch.valid);
    repeat (30) @(negedge clk);
  endtask

  function automatic tick_t rand_tick(int open_bias);
    tick_t t;
    t.operation = ($urandom_range(0, 15) == 0) ? OP_ARM : OP_TICK;
    if ($urandom_range(0, 99) < open_bias) t.mode = MODE_OPEN;
    else t.mode = 2'($urandom_range(0, 3));
    t.right_sample = 12'($urandom);
    t.left_sample = 12'($urandom);
    return t;
  endfunction

  // well-formed tape run: arm, steady window, then a drop or not
  task automatic tape_run();
    logic [11:0] rb, lb;
    int n;
    rb = 12'($urandom);
    lb = 12'($urandom);
    tick_q.push_back('{OP_ARM, 2'($urandom_range(0, 3)), rb, lb});
    n = $urandom_range(DEPTH, DEPTH + 10);
    for (int i = 0; i < n; i++) begin
      tick_t t;
      t.operation = OP_TICK;
      t.mode = MODE_OPEN;
      t.right_sample = rb + 12'($urandom_range(0, 40)) - 12'd20;
      t.left_sample = lb + 12'($urandom_range(0, 40)) - 12'd20;
      if (i > n / 2 && $urandom_range(0, 1)) begin
        if ($urandom_range(0, 1)) t.right_sample = 12'($urandom_range(0, 200));
        else t.left_sample = 12'($urandom_range(0, 200));
      end
      tick_q.push_back(t);
    end
  endtask

  initial begin
    p_right_open = 0; p_left_open = 0; p_target = 0;
    p_left_nom = NOMINAL_RESET; p_right_nom = NOMINAL_RESET; p_threshold = 0;
    p_prop = PROP_GAIN_RESET; p_deriv = DERIV_GAIN_RESET;
    p_prev_mode = MODE_OFF; p_watch = 0; p_fill = 0;
    p_prev_err = 0; p_prev_ctrl = 0;
    for (int i = 0; i < DEPTH; i++) begin
      p_rwin[i] = 0;
      p_lwin[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, extremes of the fields, every mode
    set_reg(REG_RIGHT_OPEN, 16'd37);
    set_reg(REG_LEFT_OPEN, 16'd100);
    tick_q.push_back('{OP_TICK, MODE_OFF, 12'd0, 12'd0});
    tick_q.push_back('{OP_TICK, MODE_OPEN, 12'hfff, 12'd0});
    tick_q.push_back('{OP_TICK, MODE_OFF, 12'd0, 12'hfff});
    tick_q.push_back('{OP_TICK, MODE_OFF, 12'd0, 12'hfff});
    tick_q.push_back('{OP_TICK, MODE_POS, 12'hfff, 12'd0});
    tick_q.push_back('{OP_TICK, MODE_POS, 12'd0, 12'hfff});
    tick_q.push_back('{OP_TICK, MODE_POS, 12'd100, 12'd100});
    tick_q.push_back('{OP_TICK, 2'd3, 12'd5, 12'd5});
    tick_q.push_back('{OP_TICK, MODE_OFF, 12'd5, 12'd5});
    tick_q.push_back('{OP_ARM, MODE_POS, 12'hfff, 12'hfff});
    for (int i = 0; i < DEPTH + 1; i++)
      tick_q.push_back('{OP_TICK, MODE_OPEN, (i < DEPTH - 3) ? 12'hfff : 12'd0, 12'hfff});
    drain();

    // settings sweep including extremes and deriv above prop
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(REG_RIGHT_OPEN, ph == 0 ? 16'd127 : 16'($urandom_range(0, 100)));
      set_reg(REG_LEFT_OPEN, ph == 1 ? 16'd0 : 16'($urandom_range(0, 100)));
      set_reg(REG_TARGET, ph == 0 ? 16'h0fff : ph == 1 ? 16'h1001 : 16'($urandom));
      set_reg(REG_LEFT_NOM, ph == 2 ? 16'd127 : ph == 3 ? 16'd0 : 16'($urandom_range(0, 100)));
      set_reg(REG_RIGHT_NOM, ph == 2 ? 16'd0 : ph == 3 ? 16'd127 : 16'($urandom_range(0, 100)));
      set_reg(REG_THRESHOLD, ph == 4 ? 16'hffff : ph == 5 ? 16'd0 : 16'($urandom_range(0, 300)));
      set_reg(REG_PROP_GAIN, ph == 6 ? 16'hffff : ph == 7 ? 16'd0 : 16'($urandom));
      set_reg(REG_DERIV_GAIN, ph == 6 ? 16'd0 : ph == 7 ? 16'hffff : 16'($urandom));
      for (int k = 0; k < 3; k++) tape_run();
      for (int k = 0; k < 20; k++) tick_q.push_back(rand_tick(30));
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (mismatches == 0 && duty_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
